### rtl/core/spd_pkg.sv
// Package for the space packet header deframer: header constants, phase and
// status codes, configuration and result types, and the checksum step.
// No dependencies; every other file of the block but spd_channels imports it.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  // Header layout: six primary bytes, three secondary bytes, one checksum byte.
  localparam int unsigned HDR_LEN       = 10;
  localparam int unsigned HDR_STORE_LEN = HDR_LEN - 1;
  localparam int unsigned POS_W         = $clog2(HDR_LEN);

  // Bytes counted by the data length field that are not payload (the secondary header).
  localparam logic [15:0] DLEN_OVERHEAD = 16'd3;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_VERSION  = 3'd2,
    ST_NO_SEC   = 3'd3,
    ST_APID     = 3'd4,
    ST_FRAG     = 3'd5,
    ST_LENGTH   = 3'd6
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_EXPECTED_APID   = 2'd0,
    CFG_MAX_PAYLOAD_LEN = 2'd1,
    CFG_MAX_DATA_LENGTH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] expected_apid;
    logic [15:0] max_payload_len;
    logic [15:0] max_data_length;
  } cfg_t;

  typedef logic [HDR_STORE_LEN-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  out_byte;
    logic        is_last;
    logic [2:0]  status;
    logic        pkt_type;
    logic [1:0]  seq_flags;
    logic [13:0] seq_count;
    logic [15:0] datagram_number;
    logic [3:0]  fragment_count;
    logic [3:0]  fragment_index;
    logic [15:0] data_length;
  } result_t;

  // Outcome of the header checks, handed from the checker to the sequencer.
  typedef struct packed {
    status_t     status;
    logic        payload_follows;
    logic [15:0] payload_len;
    result_t     res;
  } hdr_verdict_t;

  // Ones' complement add of the inverted byte with end-around carry. The sum
  // of two 8-bit values plus the carry never overflows a second time.
  function automatic logic [7:0] sum_add(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, ~b};
    return s[7:0] + {7'b0, s[8]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/spd_channels.sv
// Channel interfaces of the deframer: the byte input channel and the result
// channel, each with valid/ready and its payload. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       packet_start;

  modport source (output valid, output in_byte, output packet_start, input ready);
  modport sink   (input valid, input in_byte, input packet_start, output ready);
endinterface

interface spd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  out_byte;
  logic        is_last;
  logic [2:0]  status;
  logic        pkt_type;
  logic [1:0]  seq_flags;
  logic [13:0] seq_count;
  logic [15:0] datagram_number;
  logic [3:0]  fragment_count;
  logic [3:0]  fragment_index;
  logic [15:0] data_length;

  modport source (output valid, output item_kind, output out_byte, output is_last,
                  output status, output pkt_type, output seq_flags,
                  output seq_count, output datagram_number,
                  output fragment_count, output fragment_index,
                  output data_length, input ready);
  modport sink   (input valid, input item_kind, input out_byte, input is_last,
                  input status, input pkt_type, input seq_flags,
                  input seq_count, input datagram_number,
                  input fragment_count, input fragment_index,
                  input data_length, output ready);
endinterface

`default_nettype wire

### rtl/core/spd_hdr_check.sv
// Header decode and validation: splits the stored header into its fields and
// picks the first failing check. Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spd_hdr_check (
  input  spd_pkg::hdr_bytes_t   hdr,
  input  logic [7:0]            check_byte,
  input  logic [7:0]            running_sum,
  input  spd_pkg::cfg_t         cfg,
  output spd_pkg::hdr_verdict_t verdict
);
  import spd_pkg::*;

  logic [2:0]  version;
  logic        sec_flag;
  logic [10:0] apid;
  logic [15:0] dlen;
  logic [15:0] pay_len;
  logic [3:0]  fcount;
  logic [3:0]  findex;
  status_t     status;

  assign version  = hdr[0][7:5];
  assign sec_flag = hdr[0][3];
  assign apid     = {hdr[0][2:0], hdr[1]};
  assign dlen     = {hdr[4], hdr[5]};
  assign fcount   = hdr[8][7:4];
  assign findex   = hdr[8][3:0];
  assign pay_len  = dlen - DLEN_OVERHEAD;

  always_comb begin
    priority if (running_sum != check_byte) begin
      status = ST_CHECKSUM;
    end else if (version != 3'd0) begin
      status = ST_VERSION;
    end else if (!sec_flag) begin
      status = ST_NO_SEC;
    end else if (apid != cfg.expected_apid) begin
      status = ST_APID;
    end else if (findex >= fcount) begin
      status = ST_FRAG;
    end else if (dlen < DLEN_OVERHEAD || pay_len > cfg.max_payload_len ||
                 dlen > cfg.max_data_length) begin
      status = ST_LENGTH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    verdict.status              = status;
    verdict.payload_follows     = (status == ST_OK) && (pay_len != 16'd0);
    verdict.payload_len         = pay_len;
    verdict.res.item_kind       = KIND_HEADER;
    verdict.res.out_byte        = 8'd0;
    verdict.res.is_last         = !verdict.payload_follows;
    verdict.res.status          = status;
    verdict.res.pkt_type        = hdr[0][4];
    verdict.res.seq_flags       = hdr[2][7:6];
    verdict.res.seq_count       = {hdr[2][5:0], hdr[3]};
    verdict.res.datagram_number = {hdr[6], hdr[7]};
    verdict.res.fragment_count  = fcount;
    verdict.res.fragment_index  = findex;
    verdict.res.data_length     = dlen;
  end

endmodule

`default_nettype wire

### rtl/core/space_packet_header_deframer.sv
// Top level of the space packet header deframer: input register, packet
// sequencer with header store and checksum, result register.
// Depends on spd_pkg, spd_channels (spd_in_if, spd_out_if) and spd_hdr_check.
//
//   channel  | dir | transfer moves
//   ---------+-----+-------------------------------------------------
//   in_ch    | in  | one packet byte and its packet_start flag
//   out_ch   | out | one header result or one payload byte result
//   cfg_*    | in  | one register write (index, data), no handshake
//
// One byte is taken per cycle unless the output stalls. A byte passes the
// input register and then the result register before its result is on
// out_ch. Reset is synchronous and clears all control state and the valid
// flags, not the data registers. A stalled output holds its result, and
// in_ch.ready drops only while both registers are full and out_ch.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module space_packet_header_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  spd_in_if.sink                         in_ch,
  spd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [spd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spd_pkg::*;

  cfg_t         cfg_r;

  logic         s1_v_r;
  logic [7:0]   s1_byte_r;
  logic         s1_start_r;

  phase_t       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic [15:0]  left_r, left_nxt;
  hdr_bytes_t   hdr_r, hdr_nxt;

  logic         out_v_r;
  result_t      out_r, res_nxt;
  logic         emit;

  logic         out_free;
  logic         s1_adv;
  hdr_verdict_t verdict;

  phase_t       ph_eff;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]   sum_eff;
  logic [15:0]  left_eff;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;

  // The header checks only run when the checksum byte arrives without a
  // start flag, so they can look at the stored sum directly.
  spd_hdr_check u_hdr_check (
    .hdr         (hdr_r),
    .check_byte  (s1_byte_r),
    .running_sum (sum_r),
    .cfg         (cfg_r),
    .verdict     (verdict)
  );

  always_comb begin
    // A start flag restarts the header whatever phase the packet was in.
    ph_eff   = s1_start_r ? PH_HEADER : phase_r;
    pos_eff  = s1_start_r ? '0 : pos_r;
    sum_eff  = s1_start_r ? 8'd0 : sum_r;
    left_eff = s1_start_r ? 16'd0 : left_r;

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    hdr_nxt   = hdr_r;
    emit      = 1'b0;
    res_nxt   = '0;

    if (s1_adv) begin
      phase_nxt = ph_eff;
      pos_nxt   = pos_eff;
      sum_nxt   = sum_eff;
      left_nxt  = left_eff;
      unique case (ph_eff)
        PH_HEADER: begin
          if (pos_eff < POS_W'(HDR_STORE_LEN)) begin
            for (int i = 0; i < HDR_STORE_LEN; i++) begin
              if (pos_eff == POS_W'(i)) begin
                hdr_nxt[i] = s1_byte_r;
              end
            end
            sum_nxt = sum_add(sum_eff, s1_byte_r);
            pos_nxt = pos_eff + POS_W'(1);
          end else begin
            pos_nxt = '0;
            emit    = 1'b1;
            res_nxt = verdict.res;
            if (verdict.payload_follows) begin
              left_nxt  = verdict.payload_len;
              phase_nxt = PH_PAYLOAD;
            end else begin
              left_nxt  = 16'd0;
              phase_nxt = (verdict.status == ST_OK) ? PH_IDLE : PH_DROP;
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt          = left_eff - 16'd1;
          emit              = 1'b1;
          res_nxt.item_kind = KIND_PAYLOAD;
          res_nxt.out_byte  = s1_byte_r;
          if (left_nxt == 16'd0) begin
            res_nxt.is_last = 1'b1;
            phase_nxt       = PH_IDLE;
          end
        end
        PH_IDLE, PH_DROP: begin
          // Stray bytes are ignored.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_apid   <= 11'd0;
      cfg_r.max_payload_len <= 16'd1024;
      cfg_r.max_data_length <= 16'd1027;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_EXPECTED_APID:   cfg_r.expected_apid   <= cfg_data[10:0];
        CFG_MAX_PAYLOAD_LEN: cfg_r.max_payload_len <= cfg_data;
        CFG_MAX_DATA_LENGTH: cfg_r.max_data_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      sum_r   <= 8'd0;
      left_r  <= 16'd0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (out_free) begin
        out_v_r <= emit;
      end
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
    end
  end

  // Payload registers; the header store is fully rewritten before any use.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r  <= in_ch.in_byte;
      s1_start_r <= in_ch.packet_start;
    end
    if (emit) begin
      out_r <= res_nxt;
    end
    hdr_r <= hdr_nxt;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.item_kind       = out_r.item_kind;
  assign out_ch.out_byte        = out_r.out_byte;
  assign out_ch.is_last         = out_r.is_last;
  assign out_ch.status          = out_r.status;
  assign out_ch.pkt_type        = out_r.pkt_type;
  assign out_ch.seq_flags       = out_r.seq_flags;
  assign out_ch.seq_count       = out_r.seq_count;
  assign out_ch.datagram_number = out_r.datagram_number;
  assign out_ch.fragment_count  = out_r.fragment_count;
  assign out_ch.fragment_index  = out_r.fragment_index;
  assign out_ch.data_length     = out_r.data_length;

endmodule

`default_nettype wire

### rtl/core/spd_checker.sv
// Port-level checks for the space packet header deframer, bound to the top
// level. Depends on spd_pkg and spd_channels.
`timescale 1ns / 1ps
`default_nettype none

module spd_checker (
  input logic        clk,
  input logic        rst_n,
  spd_in_if.sink     in_ch,
  spd_out_if.source  out_ch
);
  import spd_pkg::*;

  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;

  // A result held back by the sink must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.out_byte) && $stable(out_ch.is_last) &&
      $stable(out_ch.item_kind) && $stable(out_ch.status))
    else $error("result changed while stalled");

  // Payload results carry no header information.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.item_kind == KIND_PAYLOAD |->
      out_ch.status == ST_OK && out_ch.data_length == 16'd0 &&
      out_ch.datagram_number == 16'd0 && out_ch.seq_count == 14'd0)
    else $error("payload result with header fields set");

  // A rejected header ends its packet.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.item_kind == KIND_HEADER && out_ch.status != ST_OK |->
      out_ch.is_last && out_ch.out_byte == 8'd0)
    else $error("rejected header not marked last");

  // A good header is last exactly when it announces no payload bytes.
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.item_kind == KIND_HEADER && out_ch.status == ST_OK |->
      out_ch.is_last == (out_ch.data_length == 16'd3))
    else $error("good header last mark disagrees with data length");

  // An idle output never blocks the input side.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid && !in_ch.ready |=> in_ch.ready || in_xfer)
    else $error("input stalled with an empty output");

endmodule

bind space_packet_header_deframer spd_checker u_spd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

### test/space_packet_header_deframer_tb.sv
// Self-checking testbench for space_packet_header_deframer: a behavioral tracker
// predicts every header and payload result and checks the block's output stream.
// Depends on spd_pkg, the spd_in_if/spd_out_if interfaces and the deframer RTL.
`timescale 1ns / 1ps

module space_packet_header_deframer_tb;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_PHASE_ITEMS = 210;

  typedef struct packed {
    logic [2:0]  version;
    logic        ptype;
    logic        sec;
    logic [10:0] apid;
    logic [1:0]  sflags;
    logic [13:0] scount;
    logic [15:0] dlen;
    logic [15:0] dgram;
    logic [3:0]  fcount;
    logic [3:0]  findex;
  } hdr_fields_t;

  // Ones' complement add of the inverted byte, carry folded back in.
  function automatic logic [7:0] ones_sum_step(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, ~b};
    return s[7:0] + 8'(s[8]);
  endfunction

  class header_deframe_tracker;
    logic [10:0] apid_reg;
    logic [15:0] max_pay_reg;
    logic [15:0] max_dlen_reg;
    logic [7:0]  hdr [HDR_STORE_LEN];
    logic [3:0]  pos;
    logic [7:0]  sum;
    logic [15:0] pay_left;
    phase_t      phase;
    result_t     awaited_results[$];
    int          errors;

    function void clear();
      apid_reg     = 11'd0;
      max_pay_reg  = 16'd1024;
      max_dlen_reg = 16'd1027;
      foreach (hdr[i]) hdr[i] = 8'h00;
      pos      = '0;
      sum      = '0;
      pay_left = '0;
      phase    = PH_IDLE;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_EXPECTED_APID:   apid_reg = v[10:0];
        CFG_MAX_PAYLOAD_LEN: max_pay_reg = v;
        CFG_MAX_DATA_LENGTH: max_dlen_reg = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      result_t     r;
      status_t     verdict;
      logic [15:0] dlen;
      logic [10:0] apid;
      logic [3:0]  fcount;
      logic [3:0]  findex;
      if (first) begin
        phase    = PH_HEADER;
        pos      = '0;
        sum      = '0;
        pay_left = '0;
      end
      r = '0;
      case (phase)
        PH_HEADER: begin
          if (pos < HDR_STORE_LEN) begin
            hdr[pos] = b;
            sum = ones_sum_step(sum, b);
            pos++;
          end else begin
            // This byte is the checksum; the header is judged now.
            pos    = '0;
            apid   = {hdr[0][2:0], hdr[1]};
            dlen   = {hdr[4], hdr[5]};
            fcount = hdr[8][7:4];
            findex = hdr[8][3:0];
            if (sum != b) verdict = ST_CHECKSUM;
            else if (hdr[0][7:5] != 3'd0) verdict = ST_VERSION;
            else if (!hdr[0][3]) verdict = ST_NO_SEC;
            else if (apid != apid_reg) verdict = ST_APID;
            else if (findex >= fcount) verdict = ST_FRAG;
            else if (dlen < 16'd3 || int'(dlen) - 3 > int'(max_pay_reg) ||
                     dlen > max_dlen_reg) verdict = ST_LENGTH;
            else verdict = ST_OK;
            pay_left = '0;
            if (verdict == ST_OK && dlen != 16'd3) begin
              pay_left = dlen - 16'd3;
              phase = PH_PAYLOAD;
            end else begin
              phase = (verdict == ST_OK) ? PH_IDLE : PH_DROP;
            end
            r.item_kind       = KIND_HEADER;
            r.is_last         = (phase != PH_PAYLOAD);
            r.status          = verdict;
            r.pkt_type        = hdr[0][4];
            r.seq_flags       = hdr[2][7:6];
            r.seq_count       = {hdr[2][5:0], hdr[3]};
            r.datagram_number = {hdr[6], hdr[7]};
            r.fragment_count  = fcount;
            r.fragment_index  = findex;
            r.data_length     = dlen;
            awaited_results.push_back(r);
          end
        end
        PH_PAYLOAD: begin
          pay_left--;
          r.item_kind = KIND_PAYLOAD;
          r.out_byte  = b;
          if (pay_left == 16'd0) begin
            r.is_last = 1'b1;
            phase = PH_IDLE;
          end
          awaited_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no expectation waiting: item_kind %0d out_byte %0d",
               got.item_kind, got.out_byte);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("item_kind", want.item_kind, got.item_kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("is_last", want.is_last, got.is_last);
      compare_field("status", want.status, got.status);
      compare_field("pkt_type", want.pkt_type, got.pkt_type);
      compare_field("seq_flags", want.seq_flags, got.seq_flags);
      compare_field("seq_count", want.seq_count, got.seq_count);
      compare_field("datagram_number", want.datagram_number, got.datagram_number);
      compare_field("fragment_count", want.fragment_count, got.fragment_count);
      compare_field("fragment_index", want.fragment_index, got.fragment_index);
      compare_field("data_length", want.data_length, got.data_length);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  spd_in_if  in_ch();
  spd_out_if out_ch();

  space_packet_header_deframer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  header_deframe_tracker tracker;
  int      cycle_count = 0;
  int      burst_left = 0;
  int      hold_left = 0;
  int      sent_items = 0;
  logic    steady = 1'b0;
  result_t seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: alternating runs of ready and stall, or always ready in steady stretches.
  always @(negedge clk) begin
    if (steady || !rst_n) begin
      out_ch.ready = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      out_ch.ready = !out_ch.ready;
      hold_left = out_ch.ready ? $urandom_range(0, 9) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.item_kind       = out_ch.item_kind;
      seen.out_byte        = out_ch.out_byte;
      seen.is_last         = out_ch.is_last;
      seen.status          = out_ch.status;
      seen.pkt_type        = out_ch.pkt_type;
      seen.seq_flags       = out_ch.seq_flags;
      seen.seq_count       = out_ch.seq_count;
      seen.datagram_number = out_ch.datagram_number;
      seen.fragment_count  = out_ch.fragment_count;
      seen.fragment_index  = out_ch.fragment_index;
      seen.data_length     = out_ch.data_length;
      tracker.check_result(seen);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        = 1'b1;
    in_ch.in_byte      = b;
    in_ch.packet_start = first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_byte(b, first);
    @(negedge clk);
  endtask

  // Sends the header (checksum xor flip) and then random bytes up to total.
  task automatic send_packet(input hdr_fields_t h, input logic [7:0] flip, input int total);
    logic [7:0] hb [HDR_LEN];
    logic [7:0] acc;
    int i;
    hb[0] = {h.version, h.ptype, h.sec, h.apid[10:8]};
    hb[1] = h.apid[7:0];
    hb[2] = {h.sflags, h.scount[13:8]};
    hb[3] = h.scount[7:0];
    hb[4] = h.dlen[15:8];
    hb[5] = h.dlen[7:0];
    hb[6] = h.dgram[15:8];
    hb[7] = h.dgram[7:0];
    hb[8] = {h.fcount, h.findex};
    acc = 8'h00;
    for (i = 0; i < HDR_STORE_LEN; i++) acc = ones_sum_step(acc, hb[i]);
    hb[9] = acc ^ flip;
    for (i = 0; i < total; i++) send_byte((i < HDR_LEN) ? hb[i] : 8'($urandom), i == 0);
    sent_items += total;
  endtask

  // Wait until every expected result has come, then let the pipeline empty.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] apid, input logic [15:0] max_pay,
                           input logic [15:0] max_dlen);
    logic [15:0] vals [3];
    cfg_idx_t idx;
    int i;
    vals = '{apid, max_pay, max_dlen};
    settle();
    for (i = 0; i < 3; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we   = 1'b1;
      cfg_addr = idx;
      cfg_data = vals[i];
      @(negedge clk);
      tracker.write_reg(idx, vals[i]);
    end
    cfg_we = 1'b0;
  endtask

  // Payload size that the current limits accept; mostly short.
  function automatic int pick_payload();
    int lim;
    int p;
    int r;
    lim = int'(tracker.max_dlen_reg) - 3;
    if (int'(tracker.max_pay_reg) < lim) lim = int'(tracker.max_pay_reg);
    r = $urandom_range(0, 99);
    if (r < 70) p = $urandom_range(0, 16);
    else if (r < 95) p = $urandom_range(17, 200);
    else p = $urandom_range(201, 600);
    if (lim < 0) return 0;
    return (p > lim) ? lim : p;
  endfunction

  function automatic hdr_fields_t good_header(input int pay);
    hdr_fields_t h;
    h.version = 3'd0;
    h.ptype   = 1'($urandom_range(0, 1));
    h.sec     = 1'b1;
    h.apid    = tracker.apid_reg;
    h.sflags  = 2'($urandom_range(0, 3));
    h.scount  = 14'($urandom_range(0, 16383));
    h.dgram   = 16'($urandom_range(0, 65535));
    h.fcount  = 4'($urandom_range(1, 15));
    h.findex  = 4'($urandom_range(0, h.fcount - 1));
    h.dlen    = 16'(pay + 3);
    return h;
  endfunction

  // A well-formed header broken in one way, followed by a few dropped bytes.
  task automatic send_faulty(input status_t kind);
    hdr_fields_t h;
    logic [7:0] flip;
    int r;
    h = good_header(pick_payload());
    flip = 8'h00;
    case (kind)
      ST_CHECKSUM: flip = 8'($urandom_range(1, 255));
      ST_VERSION:  h.version = 3'($urandom_range(1, 7));
      ST_NO_SEC:   h.sec = 1'b0;
      ST_APID:     h.apid = h.apid ^ 11'($urandom_range(1, 2047));
      ST_FRAG: begin
        h.fcount = 4'($urandom_range(0, 15));
        h.findex = 4'($urandom_range(h.fcount, 15));
      end
      default: begin
        r = $urandom_range(0, 2);
        if (r == 1 && tracker.max_pay_reg <= 16'd65531)
          h.dlen = 16'($urandom_range(int'(tracker.max_pay_reg) + 4, 65535));
        else if (r == 2 && tracker.max_dlen_reg != 16'hffff)
          h.dlen = 16'($urandom_range(int'(tracker.max_dlen_reg) + 1, 65535));
        else
          h.dlen = 16'($urandom_range(0, 2));
      end
    endcase
    send_packet(h, flip, HDR_LEN + $urandom_range(0, 6));
  endtask

  initial begin
    hdr_fields_t h;
    int r;
    int p;
    int k;
    int ph;
    int base;
    tracker = new;
    tracker.clear();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = CFG_EXPECTED_APID;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.packet_start = 1'b0;
    out_ch.ready       = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases under the reset configuration.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    h = good_header(0);
    h.ptype  = 1'b1;
    h.sflags = 2'd3;
    h.scount = 14'h3fff;
    h.dgram  = 16'hffff;
    h.fcount = 4'd15;
    h.findex = 4'd14;
    send_packet(h, 8'h00, HDR_LEN);
    h = good_header(5);
    h.ptype  = 1'b0;
    h.sflags = 2'd0;
    h.scount = 14'd0;
    h.dgram  = 16'd0;
    h.fcount = 4'd1;
    h.findex = 4'd0;
    send_packet(h, 8'h00, HDR_LEN + 5 + 2);
    for (k = 1; k <= 6; k++) send_faulty(status_t'(k));
    h = good_header(0);
    h.fcount = 4'd0;
    h.findex = 4'd0;
    send_packet(h, 8'h00, HDR_LEN);
    h = good_header(3);
    h.fcount = 4'd4;
    h.findex = 4'd4;
    send_packet(h, 8'h00, HDR_LEN + 3);
    h = good_header(1025);
    send_packet(h, 8'h00, HDR_LEN + 4);
    // The largest accepted payload; the next start cuts it short.
    h = good_header(1024);
    send_packet(h, 8'h00, HDR_LEN + 40);
    // A new start abandons a packet inside its header and inside its payload.
    send_packet(good_header(8), 8'h00, 5);
    send_packet(good_header(8), 8'h00, HDR_LEN + 3);
    send_packet(good_header(2), 8'h00, HDR_LEN + 2);

    configure(16'd2047, 16'd65532, 16'd65535);
    send_packet(good_header(65532), 8'h00, HDR_LEN + 24);
    h = good_header(2);
    h.apid = 11'd0;
    send_packet(h, 8'h00, HDR_LEN + 2);

    configure(16'd1234, 16'd65532, 16'd20);
    send_packet(good_header(18), 8'h00, HDR_LEN + 18);
    send_packet(good_header(17), 8'h00, HDR_LEN + 17);

    configure(16'($urandom_range(0, 2047)), 16'd0, 16'd3);
    send_packet(good_header(0), 8'h00, HDR_LEN);
    send_packet(good_header(1), 8'h00, HDR_LEN + 1);

    configure(16'($urandom_range(0, 2047)), 16'd0, 16'd0);
    send_packet(good_header(0), 8'h00, HDR_LEN);

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(16'($urandom_range(0, 2047)), 16'd65532, 16'd65535);
        1: configure(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 60)));
        2: configure(16'd2047, 16'($urandom_range(0, 65532)), 16'($urandom_range(0, 65535)));
        3: configure(16'd0, 16'($urandom_range(100, 700)), 16'($urandom_range(100, 700)));
        default: configure(16'($urandom_range(0, 2047)), 16'd0, 16'd65535);
      endcase
      steady = (ph == 2);
      base = sent_items;
      while (sent_items - base < RANDOM_PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) steady = !steady;
        r = $urandom_range(0, 99);
        if (r < 58) begin
          p = pick_payload();
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
          send_packet(good_header(p), 8'h00, HDR_LEN + p + k);
        end else if (r < 70) begin
          p = pick_payload();
          send_packet(good_header(p), 8'h00, $urandom_range(1, HDR_LEN - 1 + p));
        end else if (r < 88) begin
          send_faulty(status_t'($urandom_range(1, 6)));
        end else if (r < 93) begin
          // Bytes without a start flag; they count only if a packet is still open.
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
        end else if (r < 98) begin
          h.version = 3'($urandom_range(0, 7));
          h.ptype   = 1'($urandom_range(0, 1));
          h.sec     = 1'($urandom_range(0, 1));
          h.apid    = 11'($urandom_range(0, 2047));
          h.sflags  = 2'($urandom_range(0, 3));
          h.scount  = 14'($urandom_range(0, 16383));
          h.dlen    = 16'($urandom_range(0, 65535));
          h.dgram   = 16'($urandom_range(0, 65535));
          h.fcount  = 4'($urandom_range(0, 15));
          h.findex  = 4'($urandom_range(0, 15));
          send_packet(h, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom),
                      HDR_LEN + $urandom_range(0, 8));
        end else begin
          settle();
        end
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
